/* hw/rtl/bcp_pkg.sv */
// Shared constants, types and the saturation helper for the Bezier control point block.
// No dependencies; bcp_along and the top level import it.
package bcp_pkg;

	localparam int COORD_W     = 24;
	localparam int COORD_MAX   = 8388607;
	localparam int COORD_MIN   = -8388608;
	localparam int CF_W        = 16;
	localparam int CF_FRAC     = 14;
	localparam logic [CF_W-1:0] CF_RESET = 16'd4096;

	// segment length and scaled length
	localparam int DIFF_W      = COORD_W + 1;
	localparam int LEN_W       = 25;
	localparam int K_W         = 27;
	localparam int LF_W        = LEN_W + CF_W;

	// direction vector widths for the first and the second offset pass
	localparam int V1_W        = DIFF_W;
	localparam int V2_W        = 27;

	// normalized magnitude width and number of normalizer steps (16, 8, 4, 2, 1)
	localparam int NORM_W      = 30;
	localparam int NORM_STEPS  = 5;

	localparam int SUM_W       = K_W + 2;
	localparam int IN_TDATA_W  = 8 * COORD_W;
	localparam int OUT_TDATA_W = 4 * COORD_W;

	typedef logic signed [COORD_W-1:0] coord_t;

	// Clamp a wide control point coordinate into the coordinate range
	function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(COORD_MAX);
		lo = SUM_W'(COORD_MIN);
		if (v > hi) begin
			return coord_t'(hi[COORD_W-1:0]);
		end else if (v < lo) begin
			return coord_t'(lo[COORD_W-1:0]);
		end else begin
			return coord_t'(v[COORD_W-1:0]);
		end
	endfunction

endpackage

/* hw/rtl/bcp_sqrt.sv */
// Pipelined integer square root, one result bit per stage, with a payload that rides along.
// Standalone; no package needed.
module bcp_sqrt #(
	parameter int RW = 50,
	parameter int PW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [RW-1:0]     rad,
	input  logic [PW-1:0]     in_pay,
	output logic              out_valid,
	output logic [RW/2-1:0]   root,
	output logic [RW/2+1:0]   rem,
	output logic [PW-1:0]     out_pay
);

	localparam int SW  = RW / 2;
	localparam int RMW = SW + 2;

	logic [RW-1:0]  n_s    [SW];
	logic [SW-1:0]  root_s [SW];
	logic [RMW-1:0] rem_s  [SW];
	logic [PW-1:0]  pay_s  [SW];
	logic           v_s    [SW];

	for (genvar i = 0; i < SW; i++) begin : g_step
		logic [RW-1:0]  n_in;
		logic [SW-1:0]  root_in;
		logic [RMW-1:0] rem_in;
		logic [PW-1:0]  pay_in;
		logic           v_in;
		logic [RMW-1:0] rem_t;
		logic [RMW-1:0] trial;

		if (i == 0) begin : g_first
			assign n_in    = rad;
			assign root_in = '0;
			assign rem_in  = '0;
			assign pay_in  = in_pay;
			assign v_in    = in_valid;
		end else begin : g_next
			assign n_in    = n_s[i-1];
			assign root_in = root_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign pay_in  = pay_s[i-1];
			assign v_in    = v_s[i-1];
		end

		// bring down the next two radicand bits and try root*4+1
		assign rem_t = {rem_in[RMW-3:0], n_in[RW-1:RW-2]};
		assign trial = {root_in, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[i]   <= {n_in[RW-3:0], 2'b00};
				pay_s[i] <= pay_in;
				if (rem_t >= trial) begin
					rem_s[i]  <= rem_t - trial;
					root_s[i] <= {root_in[SW-2:0], 1'b1};
				end else begin
					rem_s[i]  <= rem_t;
					root_s[i] <= {root_in[SW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_s[SW-1];
	assign root      = root_s[SW-1];
	assign rem       = rem_s[SW-1];
	assign out_pay   = pay_s[SW-1];

endmodule

/* hw/rtl/bcp_div.sv */
// Pipelined restoring divider, two numerators over one divisor, one quotient bit per stage.
// Standalone; the quotient must fit in QW bits (numerator >> QW below the divisor).
module bcp_div #(
	parameter int DW = 31,
	parameter int QW = 25,
	parameter int PW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [DW+QW-1:0] num_a,
	input  logic [DW+QW-1:0] num_b,
	input  logic [DW-1:0]    den,
	input  logic [PW-1:0]    in_pay,
	output logic             out_valid,
	output logic [QW-1:0]    quo_a,
	output logic [QW-1:0]    quo_b,
	output logic [PW-1:0]    out_pay
);

	logic [DW-1:0] ra_s  [QW];
	logic [DW-1:0] rb_s  [QW];
	logic [QW-1:0] la_s  [QW];
	logic [QW-1:0] lb_s  [QW];
	logic [QW-1:0] qa_s  [QW];
	logic [QW-1:0] qb_s  [QW];
	logic [DW-1:0] den_s [QW];
	logic [PW-1:0] pay_s [QW];
	logic          v_s   [QW];

	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [DW-1:0] ra_in, rb_in, den_in;
		logic [QW-1:0] la_in, lb_in, qa_in, qb_in;
		logic [PW-1:0] pay_in;
		logic          v_in;
		logic [DW:0]   ta, tb;
		logic          ba, bb;

		if (i == 0) begin : g_first
			assign ra_in  = num_a[DW+QW-1:QW];
			assign rb_in  = num_b[DW+QW-1:QW];
			assign la_in  = num_a[QW-1:0];
			assign lb_in  = num_b[QW-1:0];
			assign qa_in  = '0;
			assign qb_in  = '0;
			assign den_in = den;
			assign pay_in = in_pay;
			assign v_in   = in_valid;
		end else begin : g_next
			assign ra_in  = ra_s[i-1];
			assign rb_in  = rb_s[i-1];
			assign la_in  = la_s[i-1];
			assign lb_in  = lb_s[i-1];
			assign qa_in  = qa_s[i-1];
			assign qb_in  = qb_s[i-1];
			assign den_in = den_s[i-1];
			assign pay_in = pay_s[i-1];
			assign v_in   = v_s[i-1];
		end

		// shift in the next numerator bit and subtract where it fits
		assign ta = {ra_in, la_in[QW-1]};
		assign tb = {rb_in, lb_in[QW-1]};
		assign ba = (ta >= {1'b0, den_in});
		assign bb = (tb >= {1'b0, den_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ra_s[i]  <= ba ? DW'(ta - {1'b0, den_in}) : ta[DW-1:0];
				rb_s[i]  <= bb ? DW'(tb - {1'b0, den_in}) : tb[DW-1:0];
				la_s[i]  <= {la_in[QW-2:0], 1'b0};
				lb_s[i]  <= {lb_in[QW-2:0], 1'b0};
				qa_s[i]  <= {qa_in[QW-2:0], ba};
				qb_s[i]  <= {qb_in[QW-2:0], bb};
				den_s[i] <= den_in;
				pay_s[i] <= pay_in;
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign quo_a     = qa_s[QW-1];
	assign quo_b     = qb_s[QW-1];
	assign out_pay   = pay_s[QW-1];

endmodule

/* hw/rtl/bcp_along.sv */
// Offset of a given magnitude along a direction vector: normalize, square, root, scale, divide.
// Uses bcp_pkg, bcp_sqrt and bcp_div. A zero vector points along +x.
module bcp_along
	import bcp_pkg::*;
#(
	parameter int VW = V1_W,
	parameter int MW = LEN_W,
	parameter int PW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [MW-1:0]        m,
	input  logic signed [VW-1:0] vx,
	input  logic signed [VW-1:0] vy,
	input  logic [PW-1:0]        in_pay,
	output logic                 out_valid,
	output logic signed [MW:0]   ox,
	output logic signed [MW:0]   oy,
	output logic [PW-1:0]        out_pay
);

	// side bundle: {m, sign x, sign y, zero, payload}
	localparam int SDW  = MW + 3 + PW;
	localparam int SQW  = 2 * NORM_W;
	localparam int RW   = SQW + 2;
	localparam int LW   = NORM_W + 1;
	localparam int NUMW = LW + MW;
	localparam int PXW  = MW + NORM_W;

	// sign and magnitude split
	logic [VW-1:0]     mag_x, mag_y;
	logic              v_s1;
	logic [NORM_W-1:0] ax_s1, ay_s1;
	logic [SDW-1:0]    side_s1;

	assign mag_x = vx[VW-1] ? (~vx + 1'b1) : vx;
	assign mag_y = vy[VW-1] ? (~vy + 1'b1) : vy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1   <= NORM_W'(mag_x);
			ay_s1   <= NORM_W'(mag_y);
			side_s1 <= {m, vx[VW-1], vy[VW-1], (vx == '0) && (vy == '0), in_pay};
		end
	end

	// normalizer: each stage shifts by a halving step while the top is clear
	logic [NORM_W-1:0] nx_s   [NORM_STEPS];
	logic [NORM_W-1:0] ny_s   [NORM_STEPS];
	logic [SDW-1:0]    nside_s[NORM_STEPS];
	logic              nv_s   [NORM_STEPS];

	for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
		localparam int SH = 1 << (NORM_STEPS - 1 - j);
		logic [NORM_W-1:0] x_in, y_in, mx;
		logic [SDW-1:0]    sd_in;
		logic              v_in;
		logic              do_sh;

		if (j == 0) begin : g_first
			assign x_in  = ax_s1;
			assign y_in  = ay_s1;
			assign sd_in = side_s1;
			assign v_in  = v_s1;
		end else begin : g_next
			assign x_in  = nx_s[j-1];
			assign y_in  = ny_s[j-1];
			assign sd_in = nside_s[j-1];
			assign v_in  = nv_s[j-1];
		end

		assign mx    = (x_in > y_in) ? x_in : y_in;
		assign do_sh = (mx[NORM_W-1 -: SH] == '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				nv_s[j] <= 1'b0;
			end else if (en) begin
				nv_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nx_s[j]    <= do_sh ? (x_in << SH) : x_in;
				ny_s[j]    <= do_sh ? (y_in << SH) : y_in;
				nside_s[j] <= sd_in;
			end
		end
	end

	// square both components
	logic              v_s2;
	logic [SQW-1:0]    sqx_s2, sqy_s2;
	logic [NORM_W-1:0] ax_s2, ay_s2;
	logic [SDW-1:0]    side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= nv_s[NORM_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2  <= SQW'(nx_s[NORM_STEPS-1]) * SQW'(nx_s[NORM_STEPS-1]);
			sqy_s2  <= SQW'(ny_s[NORM_STEPS-1]) * SQW'(ny_s[NORM_STEPS-1]);
			ax_s2   <= nx_s[NORM_STEPS-1];
			ay_s2   <= ny_s[NORM_STEPS-1];
			side_s2 <= nside_s[NORM_STEPS-1];
		end
	end

	// sum of squares
	logic              v_s3;
	logic [RW-1:0]     rad_s3;
	logic [NORM_W-1:0] ax_s3, ay_s3;
	logic [SDW-1:0]    side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3  <= RW'(sqx_s2) + RW'(sqy_s2);
			ax_s3   <= ax_s2;
			ay_s3   <= ay_s2;
			side_s3 <= side_s2;
		end
	end

	// vector length, floor of the root
	logic                       sq_v;
	logic [LW-1:0]              sq_len;
	logic [2*NORM_W+SDW-1:0]    sq_pay;

	bcp_sqrt #(
		.RW (RW),
		.PW (2 * NORM_W + SDW)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.rad       (rad_s3),
		.in_pay    ({ax_s3, ay_s3, side_s3}),
		.out_valid (sq_v),
		.root      (sq_len),
		.rem       (),
		.out_pay   (sq_pay)
	);

	logic [NORM_W-1:0] sq_ax, sq_ay;
	logic [SDW-1:0]    sq_side;
	logic [MW-1:0]     sq_m;

	assign sq_ax   = sq_pay[2*NORM_W+SDW-1 -: NORM_W];
	assign sq_ay   = sq_pay[NORM_W+SDW-1 -: NORM_W];
	assign sq_side = sq_pay[SDW-1:0];
	assign sq_m    = sq_side[SDW-1 -: MW];

	// scale by the magnitude
	logic           v_s4;
	logic [PXW-1:0] px_s4, py_s4;
	logic [LW-1:0]  len_s4;
	logic [SDW-1:0] side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s4   <= PXW'(sq_m) * PXW'(sq_ax);
			py_s4   <= PXW'(sq_m) * PXW'(sq_ay);
			len_s4  <= sq_len;
			side_s4 <= sq_side;
		end
	end

	// add half the length for rounding
	logic            v_s5;
	logic [NUMW-1:0] numx_s5, numy_s5;
	logic [LW-1:0]   len_s5;
	logic [SDW-1:0]  side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s5 <= NUMW'(px_s4) + NUMW'(len_s4[LW-1:1]);
			numy_s5 <= NUMW'(py_s4) + NUMW'(len_s4[LW-1:1]);
			len_s5  <= len_s4;
			side_s5 <= side_s4;
		end
	end

	// quotients of both components
	logic           dv;
	logic [MW-1:0]  qx, qy;
	logic [SDW-1:0] dside;

	bcp_div #(
		.DW (LW),
		.QW (MW),
		.PW (SDW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.num_a     (numx_s5),
		.num_b     (numy_s5),
		.den       (len_s5),
		.in_pay    (side_s5),
		.out_valid (dv),
		.quo_a     (qx),
		.quo_b     (qy),
		.out_pay   (dside)
	);

	logic [MW-1:0] d_m;
	logic          d_sx, d_sy, d_z;

	assign d_m  = dside[SDW-1 -: MW];
	assign d_sx = dside[PW+2];
	assign d_sy = dside[PW+1];
	assign d_z  = dside[PW];

	// apply signs; a zero vector gives (m, 0)
	logic                v_s6;
	logic signed [MW:0]  ox_s6, oy_s6;
	logic [PW-1:0]       pay_s6;
	logic signed [MW:0]  qx_w, qy_w, m_w;

	assign qx_w = $signed({1'b0, qx});
	assign qy_w = $signed({1'b0, qy});
	assign m_w  = $signed({1'b0, d_m});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (d_z) begin
				ox_s6 <= m_w;
				oy_s6 <= '0;
			end else begin
				ox_s6 <= d_sx ? -qx_w : qx_w;
				oy_s6 <= d_sy ? -qy_w : qy_w;
			end
			pay_s6 <= dside[PW-1:0];
		end
	end

	assign out_valid = v_s6;
	assign ox        = ox_s6;
	assign oy        = oy_s6;
	assign out_pay   = pay_s6;

	// normalized vector has its leading one at the top bit
	a_norm_top: assert property (@(posedge clk) disable iff (!arst_n)
		(nv_s[NORM_STEPS-1] && !nside_s[NORM_STEPS-1][PW])
			|-> (nx_s[NORM_STEPS-1][NORM_W-1] || ny_s[NORM_STEPS-1][NORM_W-1]))
		else $error("normalizer left the leading one below the top bit");

	// offset components never exceed the requested magnitude
	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(dv && !d_z) |-> (qx <= d_m && qy <= d_m))
		else $error("offset quotient above the magnitude");

	// zero vector yields a pure +x offset
	a_zero_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(dv && d_z && en) |=> (oy_s6 == '0 && ox_s6 == $past(m_w)))
		else $error("zero direction did not map to +x");

endmodule

/* hw/rtl/bezier_control_points_top.sv */
// Top level of the Bezier control point block: stream ports, length and scale stages,
// four offset units. Depends on bcp_pkg, bcp_sqrt and bcp_along (which uses bcp_div).
//
// Takes one group of four polyline points per cycle while the output is not stalled and returns
// the two cubic Bezier control points of the middle segment, one result per item, in order.
// The block is a single pipeline of 170 register stages that all advance together. The depth
// comes from the digit-serial square roots (25 stages for the segment length, 31 in each offset
// unit) and the restoring dividers (25 and 27 stages) that follow them. While the output item
// is not taken the whole pipeline holds and s_axis_tready is low. curve_factor (unsigned Q2.14)
// should be written only while no item is in flight.
module bezier_control_points_top
	import bcp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CF_W-1:0]        cfg_wr_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y (24 bits each)
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y (24 bits each)
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic en;
	logic [CF_W-1:0] curve_factor_q;

	// curviness register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_factor_q <= CF_RESET;
		end else if (cfg_wr_en) begin
			curve_factor_q <= cfg_wr_data;
		end
	end

	// advance the whole pipeline unless the output item is held
	logic v_s9;
	assign en            = !v_s9 || m_axis_tready;
	assign s_axis_tready = en;

	coord_t in_x1, in_y1, in_x2, in_y2;
	assign in_x1 = s_axis_tdata[3*COORD_W-1 -: COORD_W];
	assign in_y1 = s_axis_tdata[4*COORD_W-1 -: COORD_W];
	assign in_x2 = s_axis_tdata[5*COORD_W-1 -: COORD_W];
	assign in_y2 = s_axis_tdata[6*COORD_W-1 -: COORD_W];

	// stage 1: take the item, difference P1-P2
	logic                     v_s1;
	logic [IN_TDATA_W-1:0]    pts_s1;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pts_s1 <= s_axis_tdata;
			dx_s1  <= DIFF_W'(in_x1) - DIFF_W'(in_x2);
			dy_s1  <= DIFF_W'(in_y1) - DIFF_W'(in_y2);
		end
	end

	// stage 2: magnitudes
	logic                  v_s2;
	logic [IN_TDATA_W-1:0] pts_s2;
	logic [DIFF_W-1:0]     mx_s2, my_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pts_s2 <= pts_s1;
			mx_s2  <= dx_s1[DIFF_W-1] ? (~dx_s1 + 1'b1) : dx_s1;
			my_s2  <= dy_s1[DIFF_W-1] ? (~dy_s1 + 1'b1) : dy_s1;
		end
	end

	// stage 3: squares
	localparam int SQ_W = 2 * DIFF_W;
	logic                  v_s3;
	logic [IN_TDATA_W-1:0] pts_s3;
	logic [SQ_W-1:0]       sqx_s3, sqy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pts_s3 <= pts_s2;
			sqx_s3 <= SQ_W'(mx_s2) * SQ_W'(mx_s2);
			sqy_s3 <= SQ_W'(my_s2) * SQ_W'(my_s2);
		end
	end

	// stage 4: sum of squares
	logic                  v_s4;
	logic [IN_TDATA_W-1:0] pts_s4;
	logic [SQ_W-1:0]       rad_s4;
	logic [SQ_W:0]         rad_w;

	assign rad_w = {1'b0, sqx_s3} + {1'b0, sqy_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pts_s4 <= pts_s3;
			rad_s4 <= rad_w[SQ_W-1:0];
		end
	end

	// segment length root
	logic                  lsq_v;
	logic [LEN_W-1:0]      lsq_root;
	logic [LEN_W+1:0]      lsq_rem;
	logic [IN_TDATA_W-1:0] lsq_pts;

	bcp_sqrt #(
		.RW (SQ_W),
		.PW (IN_TDATA_W)
	) u_len_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.rad       (rad_s4),
		.in_pay    (pts_s4),
		.out_valid (lsq_v),
		.root      (lsq_root),
		.rem       (lsq_rem),
		.out_pay   (lsq_pts)
	);

	// stage 5: round the length to nearest
	logic                  v_s5;
	logic [IN_TDATA_W-1:0] pts_s5;
	logic [LEN_W-1:0]      len_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= lsq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pts_s5 <= lsq_pts;
			len_s5 <= lsq_root + LEN_W'(lsq_rem > {2'b00, lsq_root});
		end
	end

	// stage 6: length times curviness
	logic                  v_s6;
	logic [IN_TDATA_W-1:0] pts_s6;
	logic [LEN_W-1:0]      len_s6;
	logic [LF_W-1:0]       lf_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pts_s6 <= pts_s5;
			len_s6 <= len_s5;
			lf_s6  <= LF_W'(len_s5) * LF_W'(curve_factor_q);
		end
	end

	// stage 7: round the scale, form the outer segment directions
	coord_t p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;
	assign p0x = pts_s6[1*COORD_W-1 -: COORD_W];
	assign p0y = pts_s6[2*COORD_W-1 -: COORD_W];
	assign p1x = pts_s6[3*COORD_W-1 -: COORD_W];
	assign p1y = pts_s6[4*COORD_W-1 -: COORD_W];
	assign p2x = pts_s6[5*COORD_W-1 -: COORD_W];
	assign p2y = pts_s6[6*COORD_W-1 -: COORD_W];
	assign p3x = pts_s6[7*COORD_W-1 -: COORD_W];
	assign p3y = pts_s6[8*COORD_W-1 -: COORD_W];

	logic [LF_W:0] lf_rnd;
	assign lf_rnd = {1'b0, lf_s6} + (LF_W + 1)'(1 << (CF_FRAC - 1));

	logic                   v_s7;
	logic [LEN_W-1:0]       len_s7;
	logic [K_W-1:0]         k_s7;
	logic signed [V1_W-1:0] v01x_s7, v01y_s7, v23x_s7, v23y_s7;
	coord_t                 x1_s7, y1_s7, x2_s7, y2_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_s7  <= len_s6;
			k_s7    <= lf_rnd[CF_FRAC+K_W-1:CF_FRAC];
			v01x_s7 <= V1_W'(p1x) - V1_W'(p0x);
			v01y_s7 <= V1_W'(p1y) - V1_W'(p0y);
			v23x_s7 <= V1_W'(p3x) - V1_W'(p2x);
			v23y_s7 <= V1_W'(p3y) - V1_W'(p2y);
			x1_s7   <= p1x;
			y1_s7   <= p1y;
			x2_s7   <= p2x;
			y2_s7   <= p2y;
		end
	end

	// offsets of length L along P0->P1 and P2->P3
	localparam int PA1_W = 2 * COORD_W + K_W;
	logic                    a1_v;
	logic signed [LEN_W:0]   a1_ox, a1_oy, b1_ox, b1_oy;
	logic [PA1_W-1:0]        a1_pay;
	logic [2*COORD_W-1:0]    b1_pay;

	bcp_along #(
		.VW (V1_W),
		.MW (LEN_W),
		.PW (PA1_W)
	) u_along_prev (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.m         (len_s7),
		.vx        (v01x_s7),
		.vy        (v01y_s7),
		.in_pay    ({x1_s7, y1_s7, k_s7}),
		.out_valid (a1_v),
		.ox        (a1_ox),
		.oy        (a1_oy),
		.out_pay   (a1_pay)
	);

	bcp_along #(
		.VW (V1_W),
		.MW (LEN_W),
		.PW (2 * COORD_W)
	) u_along_next (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.m         (len_s7),
		.vx        (v23x_s7),
		.vy        (v23y_s7),
		.in_pay    ({x2_s7, y2_s7}),
		.out_valid (),
		.ox        (b1_ox),
		.oy        (b1_oy),
		.out_pay   (b1_pay)
	);

	// stage 8: auxiliary points and tangent directions
	localparam int AUX_W = V2_W + 1;
	coord_t         ax1, ay1, ax2, ay2;
	logic [K_W-1:0] a1_k;
	assign ax1  = a1_pay[PA1_W-1 -: COORD_W];
	assign ay1  = a1_pay[PA1_W-COORD_W-1 -: COORD_W];
	assign a1_k = a1_pay[K_W-1:0];
	assign ax2  = b1_pay[2*COORD_W-1 -: COORD_W];
	assign ay2  = b1_pay[COORD_W-1:0];

	logic signed [AUX_W-1:0] aux_ax, aux_ay, aux_bx, aux_by;
	logic signed [AUX_W-1:0] tan_ax, tan_ay, tan_bx, tan_by;

	assign aux_ax = AUX_W'(ax1) - AUX_W'(a1_ox);
	assign aux_ay = AUX_W'(ay1) - AUX_W'(a1_oy);
	assign aux_bx = AUX_W'(ax2) + AUX_W'(b1_ox);
	assign aux_by = AUX_W'(ay2) + AUX_W'(b1_oy);
	assign tan_ax = AUX_W'(ax2) - aux_ax;
	assign tan_ay = AUX_W'(ay2) - aux_ay;
	assign tan_bx = aux_bx - AUX_W'(ax1);
	assign tan_by = aux_by - AUX_W'(ay1);

	logic                   v_s8;
	logic [K_W-1:0]         k_s8;
	logic signed [V2_W-1:0] tax_s8, tay_s8, tbx_s8, tby_s8;
	coord_t                 x1_s8, y1_s8, x2_s8, y2_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= a1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s8   <= a1_k;
			tax_s8 <= tan_ax[V2_W-1:0];
			tay_s8 <= tan_ay[V2_W-1:0];
			tbx_s8 <= tan_bx[V2_W-1:0];
			tby_s8 <= tan_by[V2_W-1:0];
			x1_s8  <= ax1;
			y1_s8  <= ay1;
			x2_s8  <= ax2;
			y2_s8  <= ay2;
		end
	end

	// offsets of length K along both tangents
	logic                 a2_v;
	logic signed [K_W:0]  a2_ox, a2_oy, b2_ox, b2_oy;
	logic [2*COORD_W-1:0] a2_pay, b2_pay;

	bcp_along #(
		.VW (V2_W),
		.MW (K_W),
		.PW (2 * COORD_W)
	) u_along_tan1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s8),
		.m         (k_s8),
		.vx        (tax_s8),
		.vy        (tay_s8),
		.in_pay    ({x1_s8, y1_s8}),
		.out_valid (a2_v),
		.ox        (a2_ox),
		.oy        (a2_oy),
		.out_pay   (a2_pay)
	);

	bcp_along #(
		.VW (V2_W),
		.MW (K_W),
		.PW (2 * COORD_W)
	) u_along_tan2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s8),
		.m         (k_s8),
		.vx        (tbx_s8),
		.vy        (tby_s8),
		.in_pay    ({x2_s8, y2_s8}),
		.out_valid (),
		.ox        (b2_ox),
		.oy        (b2_oy),
		.out_pay   (b2_pay)
	);

	// stage 9: control points, saturated, into the output register
	coord_t cx1, cy1, cx2, cy2;
	assign cx1 = a2_pay[2*COORD_W-1 -: COORD_W];
	assign cy1 = a2_pay[COORD_W-1:0];
	assign cx2 = b2_pay[2*COORD_W-1 -: COORD_W];
	assign cy2 = b2_pay[COORD_W-1:0];

	logic signed [SUM_W-1:0] c1x_w, c1y_w, c2x_w, c2y_w;
	assign c1x_w = SUM_W'(cx1) + SUM_W'(a2_ox);
	assign c1y_w = SUM_W'(cy1) + SUM_W'(a2_oy);
	assign c2x_w = SUM_W'(cx2) - SUM_W'(b2_ox);
	assign c2y_w = SUM_W'(cy2) - SUM_W'(b2_oy);

	logic [OUT_TDATA_W-1:0] tdata_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= a2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tdata_s9 <= {sat_coord(c2y_w), sat_coord(c2x_w),
				sat_coord(c1y_w), sat_coord(c1x_w)};
		end
	end

	assign m_axis_tvalid = v_s9;
	assign m_axis_tdata  = tdata_s9;

endmodule
